// File: sv/core_local_timer_interruptor_macros.svh
// Assertion macros for the core-local timer interruptor.
// Needs no other file; the asserting RTL files include it.
`ifndef CORE_LOCAL_TIMER_INTERRUPTOR_MACROS_SVH
`define CORE_LOCAL_TIMER_INTERRUPTOR_MACROS_SVH
`ifndef SYNTH
`define CLTI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLTI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`CLTI_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define CLTI_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLTI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/cltint_pkg.sv
// Shared types, register map and helpers of the core-local timer interruptor.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package cltint_pkg;

	localparam int TIME_DIVIDER = 2;
	localparam int PHASE_W = (TIME_DIVIDER > 1) ? $clog2(TIME_DIVIDER) : 1;

	// register map, 17 bits so that base + length cannot overflow
	localparam logic [16:0] SOFT_BASE = 17'h00000;
	localparam logic [16:0] SOFT_SIZE = 17'h00004;
	localparam logic [16:0] CMP_BASE  = 17'h04000;
	localparam logic [16:0] CMP_SIZE  = 17'h00008;
	localparam logic [16:0] TIME_BASE = 17'h0BFF8;
	localparam logic [16:0] TIME_SIZE = 17'h00008;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_LOAD  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SEL_SOFT = 2'd0,
		SEL_CMP  = 2'd1,
		SEL_TIME = 2'd2
	} reg_sel_t;

	typedef struct packed {
		logic       hit;
		reg_sel_t   sel;
		logic [2:0] offs;
		logic [7:0] byte_mask;
	} access_t;

	function automatic logic [7:0] len_mask(input logic [2:0] len);
		logic [7:0] m;
		case (len)
			3'd1: m = 8'h01;
			3'd2: m = 8'h03;
			3'd3: m = 8'h07;
			3'd4: m = 8'h0F;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] expand_bytes(input logic [7:0] m);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = {8{m[i]}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/core_local_timer_interruptor.sv
// Core-local timer interruptor for one hart: a software-interrupt word at 0x0000, a 64-bit
// time compare at 0x4000 and a 64-bit time counter at 0xBFF8, reached by byte accesses of
// one to four bytes that must lie inside one register. Ticks advance time once every
// TIME_DIVIDER ticks, the first tick included; a load sets the counter. Every item gives
// one result, registered in the result register after the input register; items flow at
// one per cycle unless the receiver stalls, set by the single decode and byte merge.
// Depends on cltint_pkg, cltint_decode, cltint_regs and the macros header.
`default_nettype none
`include "core_local_timer_interruptor_macros.svh"
module core_local_timer_interruptor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] addr,
	input  wire logic [2:0]  length,
	input  wire logic [31:0] write_data,
	input  wire logic [63:0] time_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [31:0]      read_data,
	output logic             software_irq,
	output logic             timer_irq,
	output logic [63:0]      time_now
);
	import cltint_pkg::*;

	logic        valid_s1;
	action_t     action_s1;
	logic [15:0] addr_s1;
	logic [2:0]  length_s1;
	logic [31:0] write_data_s1;
	logic [63:0] time_value_s1;

	logic        valid_s2;
	logic        ok_s2;
	logic [31:0] read_data_s2;

	logic        take;
	logic        adv;
	access_t     acc;
	logic [31:0] rdata;
	logic        ok_c;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1     <= action_t'(action);
			addr_s1       <= addr;
			length_s1     <= length;
			write_data_s1 <= write_data;
			time_value_s1 <= time_value;
		end
		if (adv) begin
			ok_s2        <= ok_c;
			read_data_s2 <= rdata;
		end
	end

	cltint_decode u_decode (
		.addr   (addr_s1),
		.length (length_s1),
		.acc    (acc)
	);

	cltint_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (adv),
		.action       (action_s1),
		.acc          (acc),
		.write_data   (write_data_s1),
		.time_value   (time_value_s1),
		.rdata        (rdata),
		.software_irq (software_irq),
		.timer_irq    (timer_irq),
		.time_now     (time_now)
	);

	// ticks and loads always succeed
	assign ok_c = (action_s1 == ACT_TICK) || (action_s1 == ACT_LOAD) || acc.hit;

	assign out_valid = valid_s2;
	assign ok        = ok_s2;
	assign read_data = read_data_s2;

	`CLTI_ASSERT(a_time_held, clk, arst_n, (out_valid && out_stall) |=> $stable(time_now), "time changed under a stalled item")
	`CLTI_ASSERT_NEVER(a_fail_no_data, clk, arst_n, out_valid && !ok && (read_data != 32'd0), "failed access returned data")
	`CLTI_ASSERT(a_load_taken, clk, arst_n, (adv && action_s1 == ACT_LOAD) |=> (time_now == $past(time_value_s1)), "load did not reach the counter")

endmodule
`default_nettype wire

// File: sv/cltint_decode.sv
// Address decode of one bus access: which register, byte offset and byte lanes.
// Depends on cltint_pkg.
`default_nettype none
module cltint_decode (
	input  wire logic [15:0]       addr,
	input  wire logic [2:0]        length,
	output cltint_pkg::access_t    acc
);
	import cltint_pkg::*;

	logic [16:0] end_addr;
	logic [16:0] addr_x;
	logic        len_ok;

	assign addr_x   = {1'b0, addr};
	assign end_addr = addr_x + {14'd0, length};
	assign len_ok   = (length >= 3'd1) && (length <= 3'd4);

	always_comb begin
		acc.hit       = 1'b0;
		acc.sel       = SEL_SOFT;
		// every base is 8-byte aligned
		acc.offs      = addr[2:0];
		acc.byte_mask = len_mask(length) << addr[2:0];
		if (len_ok) begin
			if (addr_x >= SOFT_BASE && end_addr <= SOFT_BASE + SOFT_SIZE) begin
				acc.hit = 1'b1;
				acc.sel = SEL_SOFT;
			end else if (addr_x >= CMP_BASE && end_addr <= CMP_BASE + CMP_SIZE) begin
				acc.hit = 1'b1;
				acc.sel = SEL_CMP;
			end else if (addr_x >= TIME_BASE && end_addr <= TIME_BASE + TIME_SIZE) begin
				acc.hit = 1'b1;
				acc.sel = SEL_TIME;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/cltint_regs.sv
// Register file of the interruptor: soft word, time compare, time counter, tick phase.
// Depends on cltint_pkg; decoded access comes from cltint_decode.
`default_nettype none
module cltint_regs (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 upd,
	input  wire cltint_pkg::action_t  action,
	input  wire cltint_pkg::access_t  acc,
	input  wire logic [31:0]          write_data,
	input  wire logic [63:0]          time_value,
	output logic [31:0]               rdata,
	output logic                      software_irq,
	output logic                      timer_irq,
	output logic [63:0]               time_now
);
	import cltint_pkg::*;

	logic [31:0]        soft_q;
	logic [63:0]        cmp_q;
	logic [63:0]        time_q;
	logic [PHASE_W-1:0] phase_q;

	logic [63:0] cur;
	logic [63:0] shifted;
	logic [31:0] rmask;
	logic [63:0] wmask;
	logic [63:0] wdata64;
	logic [63:0] merged;
	logic        do_write;
	logic        do_tick;

	always_comb begin
		case (acc.sel)
			SEL_SOFT: cur = {32'd0, soft_q};
			SEL_CMP:  cur = cmp_q;
			SEL_TIME: cur = time_q;
			default:  cur = 64'd0;
		endcase
	end

	assign shifted = cur >> {acc.offs, 3'b000};
	// lanes sit at the low end again after the shift
	assign rmask   = 32'(expand_bytes(acc.byte_mask >> acc.offs));
	assign rdata   = (action == ACT_READ && acc.hit) ? (shifted[31:0] & rmask) : 32'd0;

	assign wmask    = expand_bytes(acc.byte_mask);
	assign wdata64  = {32'd0, write_data} << {acc.offs, 3'b000};
	assign merged   = (cur & ~wmask) | (wdata64 & wmask);
	assign do_write = upd && action == ACT_WRITE && acc.hit;
	assign do_tick  = upd && action == ACT_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q  <= '0;
			cmp_q   <= '0;
			time_q  <= '0;
			phase_q <= '0;
		end else begin
			if (do_write && acc.sel == SEL_SOFT) begin
				soft_q <= merged[31:0];
			end
			if (do_write && acc.sel == SEL_CMP) begin
				cmp_q <= merged;
			end
			if (do_write && acc.sel == SEL_TIME) begin
				time_q <= merged;
			end else if (upd && action == ACT_LOAD) begin
				time_q <= time_value;
			end else if (do_tick && phase_q == '0) begin
				time_q <= time_q + 64'd1;
			end
			if (do_tick) begin
				if (phase_q == PHASE_W'(TIME_DIVIDER - 1)) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + PHASE_W'(1);
				end
			end
		end
	end

	// state only moves together with the result register, so these hold with it
	assign software_irq = soft_q[0];
	assign timer_irq    = (time_q >= cmp_q);
	assign time_now     = time_q;

endmodule
`default_nettype wire

// File: bench/core_local_timer_interruptor_test.sv
// Self-checking bench for core_local_timer_interruptor: directed register accesses, then bursts
// of random bus, tick and load items, each result compared with a CLINT register predictor.
// Depends on cltint_pkg and the core_local_timer_interruptor RTL.
module core_local_timer_interruptor_test;
	import cltint_pkg::*;

	localparam int DIRECTED_COUNT  = 25;
	localparam int RANDOM_ITEMS    = 1900;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AFTER  = 400;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 200000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		action_t     act;
		logic [15:0] addr;
		logic [2:0]  len;
		logic [31:0] wdata;
		logic [63:0] tval;
		logic        typed;
		logic        t_ok;
		logic [31:0] t_rdata;
	} bus_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] rdata;
		logic        sw_irq;
		logic        tm_irq;
		logic [63:0] tnow;
	} clint_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	action_t     action = ACT_READ;
	logic [15:0] addr = '0;
	logic [2:0]  length = '0;
	logic [31:0] write_data = '0;
	logic [63:0] time_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [31:0] read_data;
	logic        software_irq;
	logic        timer_irq;
	logic [63:0] time_now;

	// predictor state
	logic [31:0] msip_q = '0;
	logic [63:0] mtimecmp_q = '0;
	logic [63:0] mtime_q = '0;
	int unsigned tick_div_q = 0;

	clint_result_t pending_results [$];
	bus_item_t     directed_items [DIRECTED_COUNT];
	int unsigned   action_count [4];
	int unsigned   rejected_count = 0;
	int unsigned   results_seen = 0;
	int unsigned   timer_irq_seen = 0;
	int unsigned   mismatches = 0;
	int unsigned   cycle_count = 0;

	core_local_timer_interruptor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.addr         (addr),
		.length       (length),
		.write_data   (write_data),
		.time_value   (time_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.read_data    (read_data),
		.software_irq (software_irq),
		.timer_irq    (timer_irq),
		.time_now     (time_now)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Advance the register state by one item and return the result it yields.
	function automatic clint_result_t predict_clint(input bus_item_t it);
		clint_result_t res;
		logic [63:0]   regval;
		logic [16:0]   base;
		int unsigned   a;
		int unsigned   n;
		int unsigned   offs;
		logic          hit;
		reg_sel_t      sel;
		res = '0;
		res.ok = 1'b1;
		a = it.addr;
		n = it.len;
		hit = 1'b0;
		sel = SEL_SOFT;
		base = SOFT_BASE;
		if (it.act == ACT_READ || it.act == ACT_WRITE) begin
			if (n >= 1 && n <= 4) begin
				if (a >= SOFT_BASE && a + n <= SOFT_BASE + SOFT_SIZE) begin
					hit = 1'b1;
					sel = SEL_SOFT;
					base = SOFT_BASE;
				end else if (a >= CMP_BASE && a + n <= CMP_BASE + CMP_SIZE) begin
					hit = 1'b1;
					sel = SEL_CMP;
					base = CMP_BASE;
				end else if (a >= TIME_BASE && a + n <= TIME_BASE + TIME_SIZE) begin
					hit = 1'b1;
					sel = SEL_TIME;
					base = TIME_BASE;
				end
			end
			res.ok = hit;
			if (hit) begin
				offs = a - base;
				case (sel)
					SEL_SOFT: regval = {32'h0, msip_q};
					SEL_CMP:  regval = mtimecmp_q;
					default:  regval = mtime_q;
				endcase
				for (int i = 0; i < n; i++) begin
					if (it.act == ACT_READ)
						res.rdata[8*i +: 8] = regval[8*(offs+i) +: 8];
					else
						regval[8*(offs+i) +: 8] = it.wdata[8*i +: 8];
				end
				if (it.act == ACT_WRITE) begin
					case (sel)
						SEL_SOFT: msip_q = regval[31:0];
						SEL_CMP:  mtimecmp_q = regval;
						default:  mtime_q = regval;
					endcase
				end
			end
		end else if (it.act == ACT_TICK) begin
			if (tick_div_q == 0)
				mtime_q++;
			tick_div_q++;
			if (tick_div_q >= TIME_DIVIDER)
				tick_div_q = 0;
		end else begin
			mtime_q = it.tval;
		end
		res.sw_irq = msip_q[0];
		res.tm_irq = (mtime_q >= mtimecmp_q);
		res.tnow = mtime_q;
		return res;
	endfunction

	// Mostly well-formed accesses and ticks; loads often land near the compare value
	// and compare/time writes near the counter to toggle the irq; a few items are pure noise.
	function automatic bus_item_t random_item();
		bus_item_t   it;
		int unsigned pick;
		int unsigned sz;
		logic [16:0] base;
		logic [63:0] target;
		it.act = ACT_READ;
		it.addr = 16'($urandom);
		it.len = 3'($urandom);
		it.wdata = $urandom;
		it.tval = {$urandom, $urandom};
		it.typed = 1'b0;
		it.t_ok = 1'b0;
		it.t_rdata = '0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			it.act = action_t'($urandom_range(0, 3));
		end else if (pick < 38) begin
			it.act = ACT_TICK;
		end else if (pick < 44) begin
			it.act = ACT_LOAD;
			case ($urandom_range(0, 3))
				0: it.tval = '1 - 64'($urandom_range(0, 3));
				1: it.tval = mtimecmp_q - 64'($urandom_range(0, 3));
				2: it.tval = mtimecmp_q + 64'($urandom_range(0, 3));
				default: ;
			endcase
		end else begin
			it.act = (pick < 72) ? ACT_READ : ACT_WRITE;
			case ($urandom_range(0, 2))
				0: begin
					base = SOFT_BASE;
					sz = SOFT_SIZE;
				end
				1: begin
					base = CMP_BASE;
					sz = CMP_SIZE;
				end
				default: begin
					base = TIME_BASE;
					sz = TIME_SIZE;
				end
			endcase
			it.len = 3'($urandom_range(1, 4));
			it.addr = 16'(base + $urandom_range(0, sz - it.len));
			if (base != SOFT_BASE && $urandom_range(0, 1) == 1) begin
				target = mtime_q + 64'($urandom_range(0, 6));
				it.wdata = 32'(target >> (8 * (it.addr - base)));
			end
		end
		return it;
	endfunction

	task automatic offer_item(input bus_item_t it);
		clint_result_t res;
		@(negedge clk);
		in_valid <= 1'b1;
		action <= it.act;
		addr <= it.addr;
		length <= it.len;
		write_data <= it.wdata;
		time_value <= it.tval;
		do @(posedge clk); while (in_stall);
		res = predict_clint(it);
		if (it.typed) begin
			res.ok = it.t_ok;
			res.rdata = it.t_rdata;
		end
		pending_results.push_back(res);
		action_count[it.act]++;
		if ((it.act == ACT_READ || it.act == ACT_WRITE) && !res.ok)
			rejected_count++;
	endtask

	task automatic idle_cycles(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		clint_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, time_now 0x%0h", $time, time_now);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (timer_irq === 1'b1)
					timer_irq_seen++;
				if (want.ok !== ok)
					report_mismatch("ok", want.ok, ok);
				if (want.rdata !== read_data)
					report_mismatch("read_data", want.rdata, read_data);
				if (want.sw_irq !== software_irq)
					report_mismatch("software_irq", want.sw_irq, software_irq);
				if (want.tm_irq !== timer_irq)
					report_mismatch("timer_irq", want.tm_irq, timer_irq);
				if (want.tnow !== time_now)
					report_mismatch("time_now", want.tnow, time_now);
			end
		end
	end

	// Receiver: segments of free flow, random stalls and periodic stalls, with one
	// long hold-off so that the block backs up into its input.
	initial begin : receiver
		stall_mode_t mode;
		int unsigned seg;
		int unsigned period;
		bit          held_off;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 2));
			seg = $urandom_range(20, 120);
			period = $urandom_range(2, 6);
			if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			for (int c = 0; c < seg; c++) begin
				@(negedge clk);
				case (mode)
					STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
					STALL_PERIODIC: out_stall <= (c % period == 0);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned burst;
		directed_items = '{
			'{ACT_READ,  16'h0000, 3'd4, 32'h0,        64'h0, 1'b1, 1'b1, 32'h0},
			'{ACT_WRITE, 16'h0000, 3'd4, 32'hFFFFFFFF, 64'h0, 1'b1, 1'b1, 32'h0},
			'{ACT_READ,  16'h0000, 3'd4, 32'h0,        64'h0, 1'b1, 1'b1, 32'hFFFFFFFF},
			'{ACT_WRITE, 16'h0000, 3'd1, 32'h00000000, 64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_READ,  16'h0003, 3'd1, 32'h0,        64'h0, 1'b1, 1'b1, 32'h000000FF},
			// crossing the end of the software word
			'{ACT_READ,  16'h0002, 3'd3, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_READ,  16'h0000, 3'd0, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_READ,  16'h0000, 3'd7, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_WRITE, 16'h0000, 3'd5, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_READ,  16'hFFFF, 3'd1, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_READ,  16'h0004, 3'd1, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_WRITE, 16'h4000, 3'd4, 32'hFFFFFFFF, 64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_WRITE, 16'h4004, 3'd4, 32'hFFFFFFFF, 64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_READ,  16'h4007, 3'd1, 32'h0,        64'h0, 1'b1, 1'b1, 32'h000000FF},
			'{ACT_LOAD,  16'h0000, 3'd0, 32'h0,        64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 32'h0},
			// counter at its maximum wraps on the first tick
			'{ACT_TICK,  16'h0000, 3'd0, 32'h0,        64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_TICK,  16'h0000, 3'd0, 32'h0,        64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_TICK,  16'h0000, 3'd0, 32'h0,        64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_WRITE, 16'hBFFC, 3'd4, 32'hA5A5A5A5, 64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_READ,  16'hBFFB, 3'd4, 32'h0,        64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_READ,  16'hBFFD, 3'd4, 32'h0,        64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_WRITE, 16'h4006, 3'd4, 32'h12345678, 64'h0, 1'b1, 1'b0, 32'h0},
			'{ACT_LOAD,  16'hFFFF, 3'd7, 32'hFFFFFFFF, 64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_WRITE, 16'h4000, 3'd2, 32'h00001234, 64'h0, 1'b0, 1'b0, 32'h0},
			'{ACT_READ,  16'h4001, 3'd2, 32'h0,        64'h0, 1'b0, 1'b0, 32'h0}
		};
		action_count = '{default: 0};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		for (int k = 0; k < DIRECTED_COUNT; k++)
			offer_item(directed_items[k]);
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				offer_item(random_item());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 6));
		end
		idle_cycles(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d reads, %0d writes, %0d ticks, %0d loads; %0d accesses rejected.",
			action_count[ACT_READ], action_count[ACT_WRITE], action_count[ACT_TICK],
			action_count[ACT_LOAD], rejected_count);
		$display("Checked %0d results, timer interrupt high in %0d, %0d mismatches.",
			results_seen, timer_irq_seen, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/cltint_pkg.sv
sv/cltint_decode.sv
sv/cltint_regs.sv
sv/core_local_timer_interruptor.sv
bench/core_local_timer_interruptor_test.sv
